// ===== design/mbts_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
package mbts_pkg;

    // Default sizes
    localparam int STORE_DEPTH_DEF = 1024;
    localparam int FRAME_MAX_DEF   = 512;
    localparam int MAX_READ_DEF    = 127;

    // Frame layout
    localparam int HDR_BYTES  = 12;
    localparam int DATA_START = 13;

    // Input modes
    localparam logic [1:0] MODE_FRAME = 2'd0;
    localparam logic [1:0] MODE_DISC  = 2'd1;
    localparam logic [1:0] MODE_IREG  = 2'd2;

    // Function codes
    localparam logic [7:0] FC_RD_COILS = 8'd1;
    localparam logic [7:0] FC_RD_DISC  = 8'd2;
    localparam logic [7:0] FC_RD_HOLD  = 8'd3;
    localparam logic [7:0] FC_RD_IREG  = 8'd4;
    localparam logic [7:0] FC_WR_COIL  = 8'd5;
    localparam logic [7:0] FC_WR_REG   = 8'd6;
    localparam logic [7:0] FC_WR_COILS = 8'd15;
    localparam logic [7:0] FC_WR_REGS  = 8'd16;
    localparam logic [7:0] FC_EXC_FLAG = 8'h80;

    // Exception codes
    localparam logic [1:0] EX_NONE  = 2'd0;
    localparam logic [1:0] EX_FUNC  = 2'd1;
    localparam logic [1:0] EX_ADDR  = 2'd2;
    localparam logic [1:0] EX_VALUE = 2'd3;

    // Request kinds after decode
    localparam logic [2:0] K_EXC    = 3'd0;
    localparam logic [2:0] K_RBIT   = 3'd1;
    localparam logic [2:0] K_RREG   = 3'd2;
    localparam logic [2:0] K_WCOIL  = 3'd3;
    localparam logic [2:0] K_WHOLD  = 3'd4;
    localparam logic [2:0] K_WCOILS = 3'd5;
    localparam logic [2:0] K_WREGS  = 3'd6;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic clr;
        logic decode;
        logic finish;
        logic hdr_push;
        logic rd_data;
        logic rd_lo;
        logic sgl_wr;
        logic fr_lo;
        logic w_lat_hi;
        logic w_lat_lo;
        logic w_wr;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic       clr_done;
        logic       short_frame;
        logic [2:0] kind;
        logic       hdr_last;
        logic       num_zero;
        logic       rd_last;
        logic       w_more;
        logic       w_byte_start;
    } t_stat;

endpackage

// ===== design/modbus_tcp_server_engine.sv =====
// Top level of the Modbus TCP server engine.
// Bytes of a request frame (mode 0) and local store loads (modes 1 and 2) are
// taken one per cycle while busy is low. The byte marked by i_frame_end starts
// processing: busy stays high through decode, the reply header, then the reads
// of coils, discrete inputs or registers one element at a time, a single write,
// or a multiple write one coil or register at a time ending in a closing check,
// and finish. Each store and the frame buffer have a single read port. A frame
// shorter than 12 bytes takes only decode and finish.
// Reply chunks appear on o_reply_* for one cycle each, marked by o_reply_valid,
// and cannot be held off by the receiver.
// After reset a clearing pass over every store address zeroes the stores with
// busy high.
module modbus_tcp_server_engine #(
    parameter int STORE_DEPTH = mbts_pkg::STORE_DEPTH_DEF,
    parameter int FRAME_MAX   = mbts_pkg::FRAME_MAX_DEF,
    parameter int MAX_READ    = mbts_pkg::MAX_READ_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    input  logic [9:0]  i_local_address,
    input  logic [15:0] i_local_value,
    output logic        o_reply_valid,
    output logic [63:0] o_reply_bytes,
    output logic [3:0]  o_reply_count,
    output logic        o_reply_last
);
    import mbts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mbts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_mode),
        .i_frame_end (i_frame_end),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    mbts_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .FRAME_MAX   (FRAME_MAX),
        .MAX_READ    (MAX_READ)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_mode          (i_mode),
        .i_frame_byte    (i_frame_byte),
        .i_local_address (i_local_address),
        .i_local_value   (i_local_value),
        .o_stat          (stat),
        .o_reply_valid   (o_reply_valid),
        .o_reply_bytes   (o_reply_bytes),
        .o_reply_count   (o_reply_count),
        .o_reply_last    (o_reply_last)
    );
endmodule

// ===== design/mbts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mbts_ram #(
    parameter int W = 8,
    parameter int D = 512
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/mbts_ctrl.sv =====
// Controller state machine: sequences clearing, decode, header, reads and writes.
module mbts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_mode,
    input  logic           i_frame_end,
    input  mbts_pkg::t_stat i_stat,
    output mbts_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import mbts_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DECODE   = 4'd2;
    localparam logic [3:0] S_HDR      = 4'd3;
    localparam logic [3:0] S_RD_ISSUE = 4'd4;
    localparam logic [3:0] S_RD_DATA  = 4'd5;
    localparam logic [3:0] S_RD_LO    = 4'd6;
    localparam logic [3:0] S_SWR      = 4'd7;
    localparam logic [3:0] S_W_CHECK  = 4'd8;
    localparam logic [3:0] S_W_LAT    = 4'd9;
    localparam logic [3:0] S_W_LAT2   = 4'd10;
    localparam logic [3:0] S_W_WR     = 4'd11;
    localparam logic [3:0] S_FINISH   = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.accept = i_start;
                if (i_start && i_mode == MODE_FRAME && i_frame_end) n_state = S_DECODE;
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state = i_stat.short_frame ? S_FINISH : S_HDR;
            end
            S_HDR: begin
                o_cmd.hdr_push = 1'b1;
                if (i_stat.hdr_last) begin
                    priority case (i_stat.kind)
                        K_RBIT, K_RREG:   n_state = i_stat.num_zero ? S_FINISH : S_RD_ISSUE;
                        K_WCOIL, K_WHOLD: n_state = S_SWR;
                        K_WCOILS, K_WREGS: n_state = S_W_CHECK;
                        default:          n_state = S_FINISH;
                    endcase
                end
            end
            S_RD_ISSUE: n_state = S_RD_DATA;
            S_RD_DATA: begin
                o_cmd.rd_data = 1'b1;
                if (i_stat.kind == K_RREG) n_state = S_RD_LO;
                else n_state = i_stat.rd_last ? S_FINISH : S_RD_ISSUE;
            end
            S_RD_LO: begin
                o_cmd.rd_lo = 1'b1;
                n_state = i_stat.rd_last ? S_FINISH : S_RD_ISSUE;
            end
            S_SWR: begin
                o_cmd.sgl_wr = 1'b1;
                n_state = S_FINISH;
            end
            S_W_CHECK: begin
                // frame read of the data byte is issued here
                if (!i_stat.w_more) n_state = S_FINISH;
                else if (i_stat.kind == K_WCOILS && !i_stat.w_byte_start) n_state = S_W_WR;
                else n_state = S_W_LAT;
            end
            S_W_LAT: begin
                o_cmd.w_lat_hi = 1'b1;
                o_cmd.fr_lo    = 1'b1;
                n_state = (i_stat.kind == K_WREGS) ? S_W_LAT2 : S_W_WR;
            end
            S_W_LAT2: begin
                o_cmd.w_lat_lo = 1'b1;
                n_state = S_W_WR;
            end
            S_W_WR: begin
                o_cmd.w_wr = 1'b1;
                n_state = S_W_CHECK;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== design/mbts_dp.sv =====
// Datapath: stores, frame capture, decode, header mux and reply packer.
module mbts_dp #(
    parameter int STORE_DEPTH = mbts_pkg::STORE_DEPTH_DEF,
    parameter int FRAME_MAX   = mbts_pkg::FRAME_MAX_DEF,
    parameter int MAX_READ    = mbts_pkg::MAX_READ_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mbts_pkg::t_cmd  i_cmd,
    input  logic [1:0]      i_mode,
    input  logic [7:0]      i_frame_byte,
    input  logic [9:0]      i_local_address,
    input  logic [15:0]     i_local_value,
    output mbts_pkg::t_stat o_stat,
    output logic            o_reply_valid,
    output logic [63:0]     o_reply_bytes,
    output logic [3:0]      o_reply_count,
    output logic            o_reply_last
);
    import mbts_pkg::*;

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int FAW = $clog2(FRAME_MAX);
    localparam int LW  = $clog2(FRAME_MAX + 1);

    // Frame capture
    logic [LW-1:0] r_len;
    logic [7:0]    r_hdr [HDR_BYTES];
    logic          fr_we;
    logic [7:0]    fr_rd;

    assign fr_we = i_cmd.accept && i_mode == MODE_FRAME && r_len < LW'(FRAME_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.finish) begin
            r_len <= '0;
        end else if (fr_we) begin
            r_len <= r_len + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fr_we && r_len < LW'(HDR_BYTES)) begin
            r_hdr[r_len[3:0]] <= i_frame_byte;
        end
    end

    // Decoded request
    logic [7:0]  r_fun;
    logic [15:0] r_addr;
    logic [15:0] r_num;
    logic [1:0]  r_err;
    logic [2:0]  r_kind;
    logic [7:0]  r_bc;
    logic [8:0]  r_rlen;
    logic [7:0]  d_fun;
    logic [15:0] d_addr;
    logic [15:0] d_num;
    logic [1:0]  d_err;
    logic [2:0]  d_kind;
    logic [7:0]  d_bc;
    logic [8:0]  d_rlen;

    always_comb begin
        d_fun  = r_hdr[7];
        d_addr = {r_hdr[8], r_hdr[9]};
        d_num  = {r_hdr[10], r_hdr[11]};
        d_err  = EX_NONE;
        if (d_fun >= FC_RD_COILS && d_fun <= FC_RD_IREG) begin
            if (d_num > 16'(MAX_READ)) d_err = EX_VALUE;
            else if (17'(d_addr) + 17'(d_num) > 17'(STORE_DEPTH)) d_err = EX_ADDR;
        end else if (d_fun != FC_WR_COIL && d_fun != FC_WR_REG &&
                     d_fun != FC_WR_COILS && d_fun != FC_WR_REGS) begin
            d_err = EX_FUNC;
        end
        if (d_fun <= FC_RD_DISC) d_bc = 8'((9'(d_num[6:0]) + 9'd7) >> 3);
        else d_bc = {d_num[6:0], 1'b0};
        if (d_err != EX_NONE) begin
            d_kind = K_EXC;
            d_rlen = 9'd9;
        end else if (d_fun <= FC_RD_IREG) begin
            d_kind = (d_fun <= FC_RD_DISC) ? K_RBIT : K_RREG;
            d_rlen = 9'd9 + 9'(d_bc);
        end else begin
            d_rlen = 9'(HDR_BYTES);
            priority case (d_fun)
                FC_WR_COIL:  d_kind = K_WCOIL;
                FC_WR_REG:   d_kind = K_WHOLD;
                FC_WR_COILS: d_kind = K_WCOILS;
                default:     d_kind = K_WREGS;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_fun  <= d_fun;
            r_addr <= d_addr;
            r_num  <= d_num;
            r_err  <= d_err;
            r_kind <= d_kind;
            r_bc   <= d_bc;
            r_rlen <= d_rlen;
        end
    end

    // Counters: clearing sweep, header byte, element index
    logic [AW-1:0] r_clr;
    logic [3:0]    r_hidx;
    logic [16:0]   r_idx;
    logic [17:0]   eaddr;

    assign eaddr = 18'(r_addr) + 18'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_hidx <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.hdr_push) r_hidx <= r_hidx + 4'd1;
            if ((i_cmd.rd_data && r_kind == K_RBIT) || i_cmd.rd_lo || i_cmd.w_wr) begin
                r_idx <= r_idx + 17'd1;
            end
        end
    end

    // Frame reads for multiple writes, zero past the received length
    logic [17:0] pos_hi;
    logic [17:0] pos_lo;
    logic [17:0] pos;
    logic        r_fvalid;
    logic [7:0]  fr_byte;
    logic [7:0]  r_wbyte;
    logic [7:0]  r_wlo;

    assign pos_hi = (r_kind == K_WCOILS) ? 18'(DATA_START) + 18'(r_idx >> 3)
                                         : 18'(DATA_START) + {r_idx, 1'b0};
    assign pos_lo = 18'(DATA_START + 1) + {r_idx, 1'b0};
    assign pos    = i_cmd.fr_lo ? pos_lo : pos_hi;
    assign fr_byte = r_fvalid ? fr_rd : 8'd0;

    always_ff @(posedge i_clk) begin
        r_fvalid <= pos < 18'(r_len);
        if (i_cmd.w_lat_hi) r_wbyte <= fr_byte;
        if (i_cmd.w_lat_lo) r_wlo   <= fr_byte;
    end

    mbts_ram #(.W(8), .D(FRAME_MAX)) u_frame (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (r_len[FAW-1:0]),
        .i_wdata (i_frame_byte),
        .i_raddr (pos[FAW-1:0]),
        .o_rdata (fr_rd)
    );

    // Store write ports
    logic [16:0]   loc17;
    logic          loc_ok;
    logic          coil_we, disc_we, hold_we, ireg_we;
    logic [AW-1:0] coil_wa, disc_wa, hold_wa, ireg_wa;
    logic          coil_wd, disc_wd;
    logic [15:0]   hold_wd, ireg_wd;
    logic          addr_ok;
    logic          coil_rd, disc_rd;
    logic [15:0]   hold_rd, ireg_rd;

    assign loc17   = 17'(i_local_address);
    assign loc_ok  = loc17 < 17'(STORE_DEPTH);
    assign addr_ok = 17'(r_addr) < 17'(STORE_DEPTH);

    always_comb begin
        coil_we = 1'b0;
        coil_wa = r_clr;
        coil_wd = 1'b0;
        hold_we = 1'b0;
        hold_wa = r_clr;
        hold_wd = 16'd0;
        if (i_cmd.clr) begin
            coil_we = 1'b1;
            hold_we = 1'b1;
        end else if (i_cmd.sgl_wr) begin
            coil_we = addr_ok && r_kind == K_WCOIL;
            coil_wa = r_addr[AW-1:0];
            coil_wd = (r_num != 16'd0);
            hold_we = addr_ok && r_kind == K_WHOLD;
            hold_wa = r_addr[AW-1:0];
            hold_wd = r_num;
        end else if (i_cmd.w_wr) begin
            coil_we = (r_kind == K_WCOILS);
            coil_wa = eaddr[AW-1:0];
            coil_wd = r_wbyte[r_idx[2:0]];
            hold_we = (r_kind == K_WREGS);
            hold_wa = eaddr[AW-1:0];
            hold_wd = {r_wbyte, r_wlo};
        end
    end

    always_comb begin
        disc_we = i_cmd.clr || (i_cmd.accept && i_mode == MODE_DISC && loc_ok);
        disc_wa = i_cmd.clr ? r_clr : loc17[AW-1:0];
        disc_wd = i_cmd.clr ? 1'b0 : i_local_value[0];
        ireg_we = i_cmd.clr || (i_cmd.accept && i_mode == MODE_IREG && loc_ok);
        ireg_wa = i_cmd.clr ? r_clr : loc17[AW-1:0];
        ireg_wd = i_cmd.clr ? 16'd0 : i_local_value;
    end

    mbts_ram #(.W(1), .D(STORE_DEPTH)) u_coil (
        .i_clk(i_clk), .i_we(coil_we), .i_waddr(coil_wa), .i_wdata(coil_wd),
        .i_raddr(eaddr[AW-1:0]), .o_rdata(coil_rd)
    );
    mbts_ram #(.W(1), .D(STORE_DEPTH)) u_disc (
        .i_clk(i_clk), .i_we(disc_we), .i_waddr(disc_wa), .i_wdata(disc_wd),
        .i_raddr(eaddr[AW-1:0]), .o_rdata(disc_rd)
    );
    mbts_ram #(.W(16), .D(STORE_DEPTH)) u_hold (
        .i_clk(i_clk), .i_we(hold_we), .i_waddr(hold_wa), .i_wdata(hold_wd),
        .i_raddr(eaddr[AW-1:0]), .o_rdata(hold_rd)
    );
    mbts_ram #(.W(16), .D(STORE_DEPTH)) u_ireg (
        .i_clk(i_clk), .i_we(ireg_we), .i_waddr(ireg_wa), .i_wdata(ireg_wd),
        .i_raddr(eaddr[AW-1:0]), .o_rdata(ireg_rd)
    );

    // Header byte select
    logic        is_write;
    logic [15:0] len_field;
    logic [7:0]  hdr_byte;
    logic [7:0]  fun_field;
    logic [7:0]  b8;

    assign is_write  = (r_kind == K_WCOIL || r_kind == K_WHOLD ||
                        r_kind == K_WCOILS || r_kind == K_WREGS);
    assign len_field = 16'(r_rlen) - 16'd6;
    assign fun_field = (r_kind == K_EXC) ? r_fun + FC_EXC_FLAG : r_fun;

    always_comb begin
        if (r_kind == K_EXC) b8 = 8'(r_err);
        else if (is_write) b8 = r_addr[15:8];
        else b8 = r_bc;
        unique case (r_hidx)
            4'd0:    hdr_byte = r_hdr[0];
            4'd1:    hdr_byte = r_hdr[1];
            4'd2:    hdr_byte = r_hdr[2];
            4'd3:    hdr_byte = r_hdr[3];
            4'd4:    hdr_byte = len_field[15:8];
            4'd5:    hdr_byte = len_field[7:0];
            4'd6:    hdr_byte = r_hdr[6];
            4'd7:    hdr_byte = fun_field;
            4'd8:    hdr_byte = b8;
            4'd9:    hdr_byte = r_addr[7:0];
            4'd10:   hdr_byte = r_num[15:8];
            4'd11:   hdr_byte = r_num[7:0];
            default: hdr_byte = 8'd0;
        endcase
    end

    // Read data: bit accumulation and register byte split
    logic [7:0]  r_acc;
    logic [7:0]  acc_n;
    logic        bit_rd;
    logic [15:0] word_rd;
    logic [7:0]  r_rlo;
    logic        rd_last;

    assign bit_rd  = (r_fun == FC_RD_COILS) ? coil_rd : disc_rd;
    assign word_rd = (r_fun == FC_RD_HOLD) ? hold_rd : ireg_rd;
    assign acc_n   = r_acc | (8'(bit_rd) << r_idx[2:0]);
    assign rd_last = (r_idx + 17'd1 == 17'(r_num));

    logic       push;
    logic [7:0] push_byte;

    always_comb begin
        push      = 1'b0;
        push_byte = hdr_byte;
        if (i_cmd.hdr_push) begin
            push = 1'b1;
        end else if (i_cmd.rd_data && r_kind == K_RBIT) begin
            push      = (r_idx[2:0] == 3'd7) || rd_last;
            push_byte = acc_n;
        end else if (i_cmd.rd_data) begin
            push      = 1'b1;
            push_byte = word_rd[15:8];
        end else if (i_cmd.rd_lo) begin
            push      = 1'b1;
            push_byte = r_rlo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_acc <= '0;
        end else if (i_cmd.rd_data && r_kind == K_RBIT) begin
            r_acc <= push ? 8'd0 : acc_n;
        end
        if (i_cmd.rd_data) r_rlo <= word_rd[7:0];
    end

    // Reply packer: eight bytes to a chunk, first byte at the top
    logic [63:0] r_pack;
    logic [2:0]  r_pcnt;
    logic [8:0]  r_ptot;
    logic [63:0] pack_n;
    logic        p_last;
    logic        r_valid;
    logic [63:0] r_obytes;
    logic [3:0]  r_ocount;
    logic        r_olast;

    assign pack_n = r_pack | (64'(push_byte) << {3'd7 - r_pcnt, 3'b000});
    assign p_last = (r_ptot + 9'd1 == r_rlen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pcnt  <= '0;
            r_ptot  <= '0;
            r_pack  <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cmd.decode) begin
                r_pcnt <= '0;
                r_ptot <= '0;
                r_pack <= '0;
            end else if (push) begin
                r_ptot <= r_ptot + 9'd1;
                if (r_pcnt == 3'd7 || p_last) begin
                    r_valid <= 1'b1;
                    r_pcnt  <= '0;
                    r_pack  <= '0;
                end else begin
                    r_pcnt <= r_pcnt + 3'd1;
                    r_pack <= pack_n;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && (r_pcnt == 3'd7 || p_last)) begin
            r_obytes <= pack_n;
            r_ocount <= 4'(r_pcnt) + 4'd1;
            r_olast  <= p_last;
        end
    end

    assign o_reply_valid = r_valid;
    assign o_reply_bytes = r_obytes;
    assign o_reply_count = r_ocount;
    assign o_reply_last  = r_olast;

    // Status
    assign o_stat.clr_done     = (r_clr == AW'(STORE_DEPTH - 1));
    assign o_stat.short_frame  = (r_len < LW'(HDR_BYTES));
    assign o_stat.kind         = r_kind;
    assign o_stat.hdr_last     = (r_hidx == (is_write ? 4'd11 : 4'd8));
    assign o_stat.num_zero     = (r_num == 16'd0);
    assign o_stat.rd_last      = rd_last;
    assign o_stat.w_more       = (r_idx < 17'(r_num)) && (eaddr < 18'(STORE_DEPTH));
    assign o_stat.w_byte_start = (r_idx[2:0] == 3'd0);
endmodule

// ===== design/mbts_chk.sv =====
// Port-level checker for the server engine, bound to the top level.
module mbts_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_mode,
    input logic        i_frame_end,
    input logic        o_reply_valid,
    input logic [3:0]  o_reply_count,
    input logic        o_reply_last
);
    import mbts_pkg::*;

    // Replies only while a request is in work
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply_valid |-> busy) else $error("reply outside busy");

    // Chunk size in range
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply_valid |-> (o_reply_count != 4'd0 && o_reply_count <= 4'd8))
        else $error("bad reply count");

    // Only the final chunk may be partial
    a_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_reply_valid && o_reply_count != 4'd8) |-> o_reply_last)
        else $error("partial chunk not last");

    // Nothing follows a final chunk directly
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_reply_valid && o_reply_last) |=> !o_reply_valid)
        else $error("chunk after last");

    // A frame end starts processing
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_FRAME && i_frame_end) |=> busy)
        else $error("frame end not taken");
endmodule

bind modbus_tcp_server_engine mbts_chk u_mbts_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_mode        (i_mode),
    .i_frame_end   (i_frame_end),
    .o_reply_valid (o_reply_valid),
    .o_reply_count (o_reply_count),
    .o_reply_last  (o_reply_last)
);

// ===== test/tb_modbus_tcp_server_engine.sv =====
// Self-checking testbench for the Modbus TCP server engine.
module tb_modbus_tcp_server_engine;
    import mbts_pkg::*;

    localparam int DEPTH = STORE_DEPTH_DEF;
    localparam int FMAX  = FRAME_MAX_DEF;
    localparam int RMAX  = MAX_READ_DEF;

    typedef struct {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        last;
    } t_chunk;

    // One directed row: a frame, a local store load or an unused-mode request
    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  fun;
        logic [15:0] addr;
        logic [15:0] num;
        int          total;   // frame bytes, 0 = natural length
        logic [1:0]  code;    // expected exception code, EX_NONE if none
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic [7:0]  i_frame_byte;
    logic        i_frame_end;
    logic [9:0]  i_local_address;
    logic [15:0] i_local_value;
    logic        o_reply_valid;
    logic [63:0] o_reply_bytes;
    logic [3:0]  o_reply_count;
    logic        o_reply_last;

    // Shadow state of the server
    logic [7:0]  frame_buf [FMAX];
    int unsigned frame_len;
    logic        coils [DEPTH];
    logic        discs [DEPTH];
    logic [15:0] hold_regs [DEPTH];
    logic [15:0] in_regs [DEPTH];

    t_chunk reply_q [$];
    int     errors;
    int     idle_pct;
    int     bytes_sent;

    modbus_tcp_server_engine uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_frame_byte   (i_frame_byte),
        .i_frame_end    (i_frame_end),
        .i_local_address(i_local_address),
        .i_local_value  (i_local_value),
        .o_reply_valid  (o_reply_valid),
        .o_reply_bytes  (o_reply_bytes),
        .o_reply_count  (o_reply_count),
        .o_reply_last   (o_reply_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("ERROR %s", msg);
    endtask

    function automatic logic [7:0] fbyte(input int unsigned pos);
        if (pos < frame_len && pos < FMAX) return frame_buf[pos];
        return 8'h00;
    endfunction

    // Decode the collected frame, apply its writes to the shadow stores and queue the reply chunks it produces
    function automatic void serve_frame();
        logic [7:0]  rep [9 + 2 * RMAX];
        logic [7:0]  fun;
        int unsigned addr, num, rlen, i, k, j, cnt;
        logic [1:0]  err;
        t_chunk      c;
        fun  = fbyte(7);
        addr = {fbyte(8), fbyte(9)};
        num  = {fbyte(10), fbyte(11)};
        err  = EX_NONE;
        foreach (rep[n]) rep[n] = 8'h00;
        if (fun >= FC_RD_COILS && fun <= FC_RD_IREG) begin
            if (num > RMAX) err = EX_VALUE;
            else if (addr + num > DEPTH) err = EX_ADDR;
        end else if (fun != FC_WR_COIL && fun != FC_WR_REG &&
                     fun != FC_WR_COILS && fun != FC_WR_REGS) begin
            err = EX_FUNC;
        end
        {rep[0], rep[1], rep[2], rep[3]} = {fbyte(0), fbyte(1), fbyte(2), fbyte(3)};
        rep[6] = fbyte(6);
        if (err != EX_NONE) begin
            rep[5] = 8'd3;
            rep[7] = fun + FC_EXC_FLAG;
            rep[8] = {6'd0, err};
            rlen = 9;
        end else if (fun <= FC_RD_IREG) begin
            rlen = (fun <= FC_RD_DISC) ? 9 + (num + 7) / 8 : 9 + 2 * num;
            {rep[4], rep[5]} = 16'(rlen - 6);
            rep[7] = fun;
            rep[8] = 8'(rlen - 9);
            for (i = 0; i < num; i++) begin
                if (fun == FC_RD_COILS)
                    rep[9 + i / 8][i % 8] = coils[addr + i];
                else if (fun == FC_RD_DISC)
                    rep[9 + i / 8][i % 8] = discs[addr + i];
                else
                    {rep[9 + 2 * i], rep[10 + 2 * i]} =
                        (fun == FC_RD_HOLD) ? hold_regs[addr + i] : in_regs[addr + i];
            end
        end else begin
            rlen = 12;
            rep[5] = 8'd6;
            rep[7] = fun;
            {rep[8], rep[9], rep[10], rep[11]} = {addr[15:0], num[15:0]};
            if (fun == FC_WR_COIL) begin
                if (addr < DEPTH) coils[addr] = (num != 0);
            end else if (fun == FC_WR_REG) begin
                if (addr < DEPTH) hold_regs[addr] = num[15:0];
            end else begin
                for (i = 0; i < num && addr + i < DEPTH; i++) begin
                    if (fun == FC_WR_COILS)
                        coils[addr + i] = 1'(fbyte(DATA_START + i / 8) >> (i % 8));
                    else
                        hold_regs[addr + i] = {fbyte(DATA_START + 2 * i),
                                               fbyte(DATA_START + 1 + 2 * i)};
                end
            end
        end
        // Pack into chunks of eight bytes
        for (k = 0; k < (rlen + 7) / 8; k++) begin
            cnt = (rlen - k * 8 > 8) ? 8 : rlen - k * 8;
            c.bytes = '0;
            for (j = 0; j < cnt; j++) c.bytes[63 - 8 * j -: 8] = rep[k * 8 + j];
            c.count = 4'(cnt);
            c.last  = (k + 1 == (rlen + 7) / 8);
            reply_q = {reply_q, c};
        end
    endfunction

    // Update shadow state for one accepted request
    function automatic void serve_request(input logic [1:0] mode, input logic [7:0] fb,
                                          input logic fe, input logic [9:0] la,
                                          input logic [15:0] lv);
        if (mode == MODE_DISC) begin
            discs[la] = lv[0];
        end else if (mode == MODE_IREG) begin
            in_regs[la] = lv;
        end else if (mode == MODE_FRAME) begin
            if (frame_len < FMAX) begin
                frame_buf[frame_len] = fb;
                frame_len++;
            end
            if (fe) begin
                if (frame_len >= HDR_BYTES) serve_frame();
                frame_len = 0;
            end
        end
    endfunction

    // Drive one request and hold it until the engine takes it
    task automatic send_request(input logic [1:0] mode, input logic [7:0] fb,
                                input logic fe, input logic [9:0] la,
                                input logic [15:0] lv);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start           <= 1'b1;
        i_mode          <= mode;
        i_frame_byte    <= fb;
        i_frame_end     <= fe;
        i_local_address <= la;
        i_local_value   <= lv;
        do @(posedge i_clk); while (busy);
        serve_request(mode, fb, fe, la, lv);
        bytes_sent++;
    endtask

    // Send a request frame; total = 0 gives the natural length
    task automatic send_frame(input logic [7:0] fun, input logic [15:0] addr,
                              input logic [15:0] num, input int total,
                              input int n_data);
        logic [7:0] fq [$];
        int         n;
        n = (total != 0) ? total : (n_data > 0 ? DATA_START + n_data : HDR_BYTES);
        fq = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom), fun, addr[15:8], addr[7:0], num[15:8],
               num[7:0]};
        while (fq.size() < n) fq = {fq, 8'($urandom)};
        for (int i = 0; i < n; i++)
            send_request(MODE_FRAME, fq[i], i == n - 1, 10'($urandom), 16'($urandom));
    endtask

    // Reply checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_reply_valid) begin
            if (reply_q.size() == 0) begin
                report_mismatch($sformatf("unexpected reply chunk %h", o_reply_bytes));
            end else begin
                if (o_reply_bytes !== reply_q[0].bytes)
                    report_mismatch($sformatf("bytes %h, expected %h",
                                              o_reply_bytes, reply_q[0].bytes));
                if (o_reply_count !== reply_q[0].count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              o_reply_count, reply_q[0].count));
                if (o_reply_last !== reply_q[0].last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              o_reply_last, reply_q[0].last));
                void'(reply_q.pop_front());
            end
        end
    end

    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    t_row rows [] = '{
        '{MODE_DISC,  8'd0, 16'd0,    16'd1,    0, EX_NONE},
        '{MODE_DISC,  8'd0, 16'd1023, 16'hFFFF, 0, EX_NONE},
        '{MODE_IREG,  8'd0, 16'd0,    16'hFFFF, 0, EX_NONE},
        '{MODE_IREG,  8'd0, 16'd1023, 16'h8000, 0, EX_NONE},
        '{2'd3,       8'd0, 16'd5,    16'h1234, 0, EX_NONE},
        '{MODE_FRAME, FC_RD_COILS, 16'd0,    16'd0,    0, EX_NONE},
        '{MODE_FRAME, FC_WR_COIL,  16'd3,    16'hFF00, 0, EX_NONE},
        '{MODE_FRAME, FC_WR_COIL,  16'd2000, 16'h0001, 0, EX_NONE},
        '{MODE_FRAME, FC_WR_REG,   16'd1023, 16'hFFFF, 0, EX_NONE},
        '{MODE_FRAME, FC_WR_COILS, 16'd0,    16'd10,   0, EX_NONE},
        '{MODE_FRAME, FC_WR_REGS,  16'd1020, 16'd8,    0, EX_NONE},
        '{MODE_FRAME, FC_WR_REGS,  16'd8,    16'd4,    DATA_START + 2, EX_NONE},
        '{MODE_FRAME, FC_RD_COILS, 16'd0,    16'd16,   0, EX_NONE},
        '{MODE_FRAME, FC_RD_DISC,  16'd0,    16'd16,   0, EX_NONE},
        '{MODE_FRAME, FC_RD_HOLD,  16'd1020, 16'd4,    0, EX_NONE},
        '{MODE_FRAME, FC_RD_IREG,  16'd1023, 16'd1,    0, EX_NONE},
        '{MODE_FRAME, FC_RD_IREG,  16'd0,    16'd127,  0, EX_NONE},
        '{MODE_FRAME, FC_RD_HOLD,  16'd0,    16'd128,  0, EX_VALUE},
        '{MODE_FRAME, FC_RD_COILS, 16'd1000, 16'd25,   0, EX_ADDR},
        '{MODE_FRAME, 8'd0,        16'd0,    16'd1,    0, EX_FUNC},
        '{MODE_FRAME, 8'd255,      16'd0,    16'd1,    0, EX_FUNC},
        '{MODE_FRAME, 8'd7,        16'hFFFF, 16'hFFFF, 0, EX_FUNC},
        '{MODE_FRAME, FC_RD_HOLD,  16'd0,    16'd2,    5, EX_NONE},
        '{MODE_FRAME, FC_RD_HOLD,  16'd0,    16'd2,    11, EX_NONE},
        '{MODE_FRAME, FC_WR_REGS,  16'd40,   16'd200,  520, EX_NONE}
    };

    initial begin
        logic [7:0]  fun;
        logic [15:0] addr, num;
        int          nd, pick;
        errors = 0;
        bytes_sent = 0;
        idle_pct = 38;
        frame_len = 0;
        foreach (coils[a]) begin
            coils[a] = 1'b0;
            discs[a] = 1'b0;
            hold_regs[a] = '0;
            in_regs[a] = '0;
        end
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_mode <= MODE_FRAME;
        i_frame_byte <= '0;
        i_frame_end <= 1'b0;
        i_local_address <= '0;
        i_local_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (rows[r]) begin
            if (rows[r].mode != MODE_FRAME) begin
                send_request(rows[r].mode, 8'($urandom), 1'b1, rows[r].addr[9:0],
                             rows[r].num);
            end else begin
                nd = 0;
                if (rows[r].fun == FC_WR_COILS) nd = (rows[r].num + 7) / 8;
                if (rows[r].fun == FC_WR_REGS)  nd = 2 * rows[r].num;
                send_frame(rows[r].fun, rows[r].addr, rows[r].num, rows[r].total, nd);
                if (rows[r].code != EX_NONE &&
                    reply_q[$].bytes[63:56] !== {6'd0, rows[r].code})
                    report_mismatch($sformatf("row %0d: exception code %h, expected %0d",
                                              r, reply_q[$].bytes[63:56], rows[r].code));
            end
        end

        // Random frames, mostly well formed, with local loads and noise mixed in
        bytes_sent = 0;
        while (bytes_sent < 400) begin
            idle_pct = (bytes_sent < 140) ? 38 : (bytes_sent < 280) ? 87 : 0;
            pick = $urandom_range(99);
            if (pick < 20) begin
                send_request(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom),
                             ($urandom_range(1) != 0) ? 10'($urandom_range(63))
                                                      : 10'($urandom),
                             16'($urandom));
            end else if (pick < 27) begin
                send_frame(8'($urandom), 16'($urandom), 16'($urandom),
                           $urandom_range(1, 20), 0);
            end else begin
                case ($urandom_range(7))
                    0: fun = FC_RD_COILS;
                    1: fun = FC_RD_DISC;
                    2: fun = FC_RD_HOLD;
                    3: fun = FC_RD_IREG;
                    4: fun = FC_WR_COIL;
                    5: fun = FC_WR_REG;
                    6: fun = FC_WR_COILS;
                    default: fun = FC_WR_REGS;
                endcase
                addr = ($urandom_range(9) < 7) ? 16'($urandom_range(63))
                                               : 16'($urandom);
                num = ($urandom_range(19) != 0) ? 16'($urandom_range(16))
                                                : 16'($urandom_range(130));
                if (fun == FC_WR_COIL || fun == FC_WR_REG) num = 16'($urandom);
                nd = 0;
                if (fun == FC_WR_COILS) nd = (num + 7) / 8;
                if (fun == FC_WR_REGS)  nd = 2 * num;
                if (nd > 0 && $urandom_range(9) == 0) nd = $urandom_range(nd);
                send_frame(fun, addr, num, 0, nd);
            end
        end
        start <= 1'b0;

        // Drain
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
design/mbts_pkg.sv
design/mbts_ram.sv
design/mbts_ctrl.sv
design/mbts_dp.sv
design/modbus_tcp_server_engine.sv
design/mbts_chk.sv
test/tb_modbus_tcp_server_engine.sv
